// File: design/dsbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsbc_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dsbc_pkg;

    localparam int N_MAX  = 65536;
    localparam int ADDR_W = $clog2(N_MAX + 1);
    localparam int SUM_W  = 20;
    localparam int LIM_W  = 24;
    localparam int CNT_W  = 17;
    localparam int FLD_W  = 17;

    typedef struct packed {
        logic build_init;
        logic build_rd;
        logic build_wr;
        logic q_load;
        logic q_issue;
        logic out_load;
    } dsbc_cmd_t;

    typedef struct packed {
        logic build_done;
        logic q_empty;
        logic q_last;
        logic out_busy;
    } dsbc_sts_t;

endpackage
`default_nettype wire

// File: design/dsbc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsbc_ctrl
// Sequencer for the table build after reset and for query walks.
// ----------------------------------------------------------------------------
module dsbc_ctrl
    import dsbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  dsbc_sts_t      sts,
    output dsbc_cmd_t      cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_BRD   = 3'd1;
    localparam logic [2:0] ST_BWR   = 3'd2;
    localparam logic [2:0] ST_IDLE  = 3'd3;
    localparam logic [2:0] ST_RUN   = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.build_init = 1'b1;
                state_next     = ST_BRD;
            end
            ST_BRD:
            begin
                cmd.build_rd = 1'b1;
                state_next   = ST_BWR;
            end
            ST_BWR:
            begin
                cmd.build_wr = 1'b1;
                state_next   = sts.build_done ? ST_IDLE : ST_BRD;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.q_load = 1'b1;
                    state_next = sts.q_empty ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.q_issue = 1'b1;
                if (sts.q_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: design/dsbc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsbc_dp
// Divisor-sum memory, sieve counters, query walk and output register.
// ----------------------------------------------------------------------------
module dsbc_dp
    import dsbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  dsbc_cmd_t              cmd,
    output dsbc_sts_t              sts,
    input  wire logic [FLD_W-1:0]  range_start,
    input  wire logic [FLD_W-1:0]  range_stop,
    input  wire logic [LIM_W-1:0]  badness_limit,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CNT_W-1:0]       match_count
);

    localparam logic [ADDR_W-1:0] NMAX_A = ADDR_W'(N_MAX);

    logic [SUM_W-1:0]  mem [0:N_MAX];
    logic [SUM_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [SUM_W-1:0]  wdata;

    // sieve: add d into every multiple m of d
    logic [ADDR_W-1:0] d_reg;
    logic [ADDR_W-1:0] m_reg;
    logic [ADDR_W:0]   m_step;
    logic              pass_end;

    // query walk
    logic [ADDR_W-1:0] n_reg;
    logic [ADDR_W-1:0] stop_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [ADDR_W-1:0] n1_reg;
    logic              v1_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] start_c;
    logic [ADDR_W-1:0] stop_c;
    logic [SUM_W:0]    twice;
    logic [SUM_W:0]    diff;
    logic              pass;

    logic              out_valid_reg;
    logic [CNT_W-1:0]  out_count_reg;

    assign m_step   = {1'b0, m_reg} + {1'b0, d_reg};
    assign pass_end = (m_step > (ADDR_W+1)'(N_MAX));

    assign we      = cmd.build_wr;
    assign wdata   = ((d_reg == ADDR_W'(1)) ? '0 : rd_data_reg) + SUM_W'(d_reg);
    assign rd_addr = cmd.build_rd ? m_reg : n_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[m_reg] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.build_init)
        begin
            d_reg <= ADDR_W'(1);
            m_reg <= ADDR_W'(1);
        end
        else if (cmd.build_wr)
        begin
            if (pass_end)
            begin
                d_reg <= d_reg + ADDR_W'(1);
                m_reg <= d_reg + ADDR_W'(1);
            end
            else
            begin
                m_reg <= m_step[ADDR_W-1:0];
            end
        end
    end

    // clamp the range to 1..N_MAX
    assign start_c = (range_start == '0) ? ADDR_W'(1) : range_start;
    assign stop_c  = (range_stop > NMAX_A) ? NMAX_A : range_stop;

    assign twice = (SUM_W+1)'({n1_reg, 1'b0});
    assign diff  = (twice >= {1'b0, rd_data_reg}) ? (twice - {1'b0, rd_data_reg})
                                                  : ({1'b0, rd_data_reg} - twice);
    assign pass  = (LIM_W'(diff) <= limit_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.q_load)
        begin
            n_reg     <= start_c;
            stop_reg  <= stop_c;
            limit_reg <= badness_limit;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.q_issue)
            begin
                n_reg <= n_reg + ADDR_W'(1);
            end
            if (v1_reg && pass)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
        n1_reg <= n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.q_issue;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_count_reg <= count_reg;
        end
    end

    assign sts.build_done = pass_end && (d_reg == NMAX_A);
    assign sts.q_empty    = (start_c > stop_c);
    assign sts.q_last     = (n_reg == stop_reg);
    assign sts.out_busy   = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign match_count = out_count_reg;

endmodule
`default_nettype wire

// File: design/divisor_sum_badness_counter.sv
// After reset the divisor-sum table is built by sieving, with in_stall high.
// A query keeps in_stall high while the walk reads sigma once per number in the range,
//   and then while the previous result is still stalled; the count is then loaded into
//   the output register once the walk has drained.
// Reset (rst_n, async low) returns the controller to the build, which rewrites the table.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// divisor_sum_badness_counter
// Counts n in a range whose |2n - sigma(n)| is within a limit.
// ----------------------------------------------------------------------------
module divisor_sum_badness_counter
    import dsbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [FLD_W-1:0]  range_start,
    input  wire logic [FLD_W-1:0]  range_stop,
    input  wire logic [LIM_W-1:0]  badness_limit,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CNT_W-1:0]       match_count
);

    // command and status between the sequencer and the datapath
    dsbc_cmd_t cmd;
    dsbc_sts_t sts;

    // sequencer: build the table, then take one transfer at a time
    dsbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: sigma memory, walk counters, compare and count
    dsbc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .range_start   (range_start),
        .range_stop    (range_stop),
        .badness_limit (badness_limit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_count   (match_count)
    );

endmodule
`default_nettype wire

// File: design/dsbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsbc_checker
// Port-level checks on the query and result transfers.
// ----------------------------------------------------------------------------
module dsbc_checker
    import dsbc_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [CNT_W-1:0] match_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match_count))
        else $error("stalled result changed");

    // one query at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // a result cannot come in the cycle after the query transfer
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

    // count never exceeds the table range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> match_count <= CNT_W'(N_MAX))
        else $error("count out of range");

endmodule

bind divisor_sum_badness_counter dsbc_checker u_dsbc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_count (match_count)
);
`default_nettype wire

// File: tb/divisor_sum_badness_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divisor_sum_badness_counter_test
// Self-checking bench: sends range queries, predicts each match count from a
// divisor-sum table of its own or a directed row, checks every result in order.
// ----------------------------------------------------------------------------
module divisor_sum_badness_counter_test;
    import dsbc_pkg::*;

    localparam int RANDOM_QUERIES = 100;
    localparam int HOLD_CYCLES    = 12000;
    localparam int PENDING_DEPTH  = 16;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        logic [FLD_W-1:0] first;
        logic [FLD_W-1:0] last;
        logic [LIM_W-1:0] limit;
        bit               known;
        logic [CNT_W-1:0] count;
    } query_row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [FLD_W-1:0] range_start;
    logic [FLD_W-1:0] range_stop;
    logic [LIM_W-1:0] badness_limit;
    logic             out_valid;
    logic             out_stall;
    logic [CNT_W-1:0] match_count;

    // sigma(n) for every n up to N_MAX, filled once at time zero
    int unsigned      divisor_sums[0:N_MAX];
    // expected counts in transfer order, kept as a ring
    logic [CNT_W-1:0] pending_counts[0:PENDING_DEPTH-1];
    int unsigned      pending_wr;
    int unsigned      pending_rd;
    int               error_count;
    int               results_seen;
    longint           cycle_count;

    divisor_sum_badness_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .range_start   (range_start),
        .range_stop    (range_stop),
        .badness_limit (badness_limit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .match_count   (match_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count n in the clamped range whose |2n - sigma(n)| stays within the limit.
    function automatic logic [CNT_W-1:0] count_matches(logic [FLD_W-1:0] first,
                                                       logic [FLD_W-1:0] last,
                                                       logic [LIM_W-1:0] limit);
        int unsigned lo;
        int unsigned hi;
        int unsigned hits;
        longint      gap;
        lo   = (first < 1) ? 1 : first;
        hi   = (last > N_MAX) ? N_MAX : last;
        hits = 0;
        for (int unsigned n = lo; n <= hi; n++)
        begin
            gap = longint'(2 * n) - longint'(divisor_sums[n]);
            if (gap < 0)
                gap = -gap;
            if (gap <= longint'(limit))
                hits++;
        end
        return hits[CNT_W-1:0];
    endfunction

    // Hold the query until it is taken, then queue its expected count.
    task automatic offer_query(query_row_t q);
        in_valid      <= 1'b1;
        range_start   <= q.first;
        range_stop    <= q.last;
        badness_limit <= q.limit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (q.known)
            pending_counts[pending_wr % PENDING_DEPTH] = q.count;
        else
            pending_counts[pending_wr % PENDING_DEPTH] = count_matches(q.first, q.last,
                                                                       q.limit);
        pending_wr++;
    endtask

    // Sender: directed table, then random queries in bursts with gaps.
    initial
    begin
        query_row_t directed_rows[$];
        query_row_t q;
        int         burst_left;
        int         gap;
        int         pick;

        in_valid      = 1'b0;
        range_start   = '0;
        range_stop    = '0;
        badness_limit = '0;
        rst_n         = 1'b0;
        error_count   = 0;
        pending_wr    = 0;
        pending_rd    = 0;

        for (int n = 0; n <= N_MAX; n++)
            divisor_sums[n] = 0;
        for (int d = 1; d <= N_MAX; d++)
            for (int m = d; m <= N_MAX; m += d)
                divisor_sums[m] += d;

        directed_rows = '{
            '{17'd1,      17'd65536,  24'hFFFFFF, 1'b1, 17'd65536},
            '{17'd1,      17'd65536,  24'h000000, 1'b0, 17'd0},
            '{17'd1,      17'd65536,  24'h000001, 1'b0, 17'd0},
            '{17'd1,      17'd1,      24'h000000, 1'b1, 17'd0},
            '{17'd1,      17'd1,      24'h000001, 1'b1, 17'd1},
            '{17'd6,      17'd6,      24'h000000, 1'b1, 17'd1},
            '{17'd0,      17'd0,      24'hFFFFFF, 1'b1, 17'd0},
            '{17'd0,      17'd10,     24'hFFFFFF, 1'b1, 17'd10},
            '{17'd100,    17'd50,     24'hFFFFFF, 1'b1, 17'd0},
            '{17'd65500,  17'd131071, 24'hFFFFFF, 1'b1, 17'd37},
            '{17'd131071, 17'd131071, 24'hFFFFFF, 1'b1, 17'd0},
            '{17'd131071, 17'd0,      24'hFFFFFF, 1'b1, 17'd0},
            '{17'd65536,  17'd65536,  24'h5555AA, 1'b0, 17'd0},
            '{17'd1,      17'd200,    24'h000005, 1'b0, 17'd0},
            '{17'd43690,  17'd43800,  24'hAAAA55, 1'b0, 17'd0},
            '{17'd21845,  17'd21900,  24'h00FFFF, 1'b0, 17'd0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // the table build keeps in_stall high; offer_query simply waits it out
        foreach (directed_rows[i])
            offer_query(directed_rows[i]);

        burst_left = 0;
        for (int k = 0; k < RANDOM_QUERIES; k++)
        begin
            // drop valid for a gap between bursts
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;

            // once, hold the sender until every queued count has come back
            if (k == 60)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_wr != pending_rd)
                    @(posedge clk);
            end

            q.known   = 1'b0;
            q.count   = '0;
            q.first   = FLD_W'($urandom_range(1, N_MAX));
            pick      = $urandom_range(0, 19);
            if (pick == 0)
                q.last = FLD_W'(q.first + $urandom_range(0, 4096));
            else
                q.last = FLD_W'(q.first + $urandom_range(0, 48));
            if (pick == 1)
                q.first = '0;
            if (pick == 2)
                q.last = FLD_W'($urandom_range(0, 2 * N_MAX - 1));
            if (pick == 3)
            begin
                q.last  = q.first;
                q.first = FLD_W'(q.first + $urandom_range(1, 30));
            end
            case ($urandom_range(0, 3))
                0: q.limit = LIM_W'($urandom_range(0, 4));
                1: q.limit = LIM_W'($urandom_range(0, 200));
                2: q.limit = LIM_W'($urandom_range(0, 20000));
                default: q.limit = LIM_W'($urandom());
            endcase
            offer_query(q);
        end
        in_valid <= 1'b0;

        while (pending_wr != pending_rd)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: check each result transfer, then pick the next stall level.
    initial
    begin
        int hold_left;
        bit hold_done;
        int phase;
        out_stall    = 1'b0;
        results_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        phase        = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_wr == pending_rd)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, match_count);
                    error_count++;
                end
                else
                begin
                    logic [CNT_W-1:0] want;
                    want = pending_counts[pending_rd % PENDING_DEPTH];
                    pending_rd++;
                    if (match_count !== want)
                    begin
                        $display("%0t: match_count mismatch, expected %0d, actual %0d",
                                 $time, want, match_count);
                        error_count++;
                    end
                end
                // once, back up the block so its input stalls under load
                if (results_seen == 30 && !hold_done)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            phase = (phase + 1) % 150;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (phase < 50)
                out_stall <= 1'b0;
            else if (phase < 100)
                out_stall <= ($urandom_range(0, 9) < 3);
            else
                out_stall <= ($urandom_range(0, 9) < 7);
        end
    end

    // Watchdog: end the run with errors if it goes past CYCLE_LIMIT.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
